// ----- rtl/tic_pkg.sv -----
// Shared types, constants and helper functions for the tax identifier
// check-digit validator. No dependencies.
package tic_pkg;

  localparam int unsigned CountW = 4;
  localparam int unsigned DigitW = 4;
  localparam int unsigned SumW   = 10;
  localparam int unsigned CharW  = 8;

  localparam logic [CountW-1:0] CountMax = 4'd15;

  // identifier kinds, as held in the mode register
  localparam logic KindIndividual = 1'b0;
  localparam logic KindCompany    = 1'b1;

  localparam logic [CountW-1:0] LenIndividual = 4'd11;
  localparam logic [CountW-1:0] LenCompany    = 4'd14;

  // digit positions that carry the received check digits
  localparam logic [CountW-1:0] IndCheck1Pos = 4'd9;
  localparam logic [CountW-1:0] IndCheck2Pos = 4'd10;
  localparam logic [CountW-1:0] CoCheck1Pos  = 4'd12;
  localparam logic [CountW-1:0] CoCheck2Pos  = 4'd13;

  localparam logic [CharW-1:0] CharZero = 8'h30;
  localparam logic [CharW-1:0] CharNine = 8'h39;

  localparam logic [6:0] ModBase = 7'd11;

  // company number weight tables
  localparam logic [3:0] CoWeightFirst [12] = '{
    4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2
  };
  localparam logic [3:0] CoWeightSecond [13] = '{
    4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2
  };

  // final state of one string, handed from the accumulator to the checker
  typedef struct packed {
    logic              len_ok;
    logic              all_equal;
    logic [SumW-1:0]   sum1;
    logic [SumW-1:0]   sum2;
    logic [DigitW-1:0] rx1;
    logic [DigitW-1:0] rx2;
  } fin_t;

  // weight of a digit in the first sum; zero past the table
  function automatic logic [3:0] weight_first(input logic kind,
                                              input logic [CountW-1:0] pos);
    logic [3:0] w;
    w = 4'd0;
    if (kind == KindIndividual) begin
      if (pos < 4'd9) w = 4'd10 - pos;
    end else begin
      if (pos < 4'd12) w = CoWeightFirst[pos];
    end
    return w;
  endfunction

  // weight of a digit in the second sum; zero past the table
  function automatic logic [3:0] weight_second(input logic kind,
                                               input logic [CountW-1:0] pos);
    logic [3:0] w;
    w = 4'd0;
    if (kind == KindIndividual) begin
      if (pos < 4'd10) w = 4'd11 - pos;
    end else begin
      if (pos < 4'd13) w = CoWeightSecond[pos];
    end
    return w;
  endfunction

  // sum mod 11: 32 is -1 mod 11, so fold the upper bits in, then trim
  function automatic logic [3:0] mod11(input logic [SumW-1:0] s);
    logic [6:0] t;
    t = 7'(s[4:0]) + 7'd33 - 7'(s[9:5]);
    for (int i = 0; i < 5; i++) begin
      if (t >= ModBase) t = t - ModBase;
    end
    return t[3:0];
  endfunction

  // expected check digit for a weighted sum
  function automatic logic [DigitW-1:0] expected_digit(input logic [SumW-1:0] s);
    logic [3:0] r;
    r = mod11(s);
    return (r < 4'd2) ? 4'd0 : 4'(ModBase[3:0] - r);
  endfunction

endpackage

// ----- rtl/tic_accum.sv -----
// Per-digit accumulator: count, first digit, equality flag, weighted sums,
// captured check digits, and the final-state register. Uses tic_pkg.
module tic_accum import tic_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             en,
  input  logic             kind,
  input  logic [CharW-1:0] char_code,
  input  logic             last_char,
  output logic             fin_valid,
  output fin_t             fin
);

  logic [CountW-1:0] digit_count, digit_count_next;
  logic [DigitW-1:0] first_digit, first_digit_next;
  logic              all_equal, all_equal_next;
  logic [SumW-1:0]   sum1, sum1_next;
  logic [SumW-1:0]   sum2, sum2_next;
  logic [DigitW-1:0] rx1, rx1_next;
  logic [DigitW-1:0] rx2, rx2_next;

  logic              is_digit;
  logic [DigitW-1:0] d;
  logic [3:0]        w1, w2;
  logic [CountW-1:0] cap1_pos, cap2_pos, len;

  // digit update
  always_comb begin
    is_digit = (char_code >= CharZero) && (char_code <= CharNine);
    d        = char_code[3:0];
    w1       = weight_first(kind, digit_count);
    w2       = weight_second(kind, digit_count);
    cap1_pos = (kind == KindIndividual) ? IndCheck1Pos : CoCheck1Pos;
    cap2_pos = (kind == KindIndividual) ? IndCheck2Pos : CoCheck2Pos;
    len      = (kind == KindIndividual) ? LenIndividual : LenCompany;

    digit_count_next = digit_count;
    first_digit_next = first_digit;
    all_equal_next   = all_equal;
    sum1_next        = sum1;
    sum2_next        = sum2;
    rx1_next         = rx1;
    rx2_next         = rx2;
    if (is_digit) begin
      if (digit_count == '0) first_digit_next = d;
      else if (d != first_digit) all_equal_next = 1'b0;
      sum1_next = sum1 + (SumW'(d) * SumW'(w1));
      sum2_next = sum2 + (SumW'(d) * SumW'(w2));
      if (digit_count == cap1_pos) rx1_next = d;
      if (digit_count == cap2_pos) rx2_next = d;
      if (digit_count < CountMax) digit_count_next = digit_count + 4'd1;
    end
  end

  // running state; cleared after the last character of a string
  always_ff @(posedge clk) begin
    if (rst || (en && last_char)) begin
      digit_count <= '0;
      first_digit <= '0;
      all_equal   <= 1'b1;
      sum1        <= '0;
      sum2        <= '0;
      rx1         <= '0;
      rx2         <= '0;
    end else if (en) begin
      digit_count <= digit_count_next;
      first_digit <= first_digit_next;
      all_equal   <= all_equal_next;
      sum1        <= sum1_next;
      sum2        <= sum2_next;
      rx1         <= rx1_next;
      rx2         <= rx2_next;
    end
  end

  // final state of a finished string
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= en && last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (en && last_char) begin
      fin.len_ok    <= (digit_count_next == len);
      fin.all_equal <= all_equal_next;
      fin.sum1      <= sum1_next;
      fin.sum2      <= sum2_next;
      fin.rx1       <= rx1_next;
      fin.rx2       <= rx2_next;
    end
  end

  a_cleared_after_last: assert property (@(posedge clk) disable iff (rst)
    (en && last_char) |=> (digit_count == '0))
    else $error("state not cleared after last item of a string");

  a_empty_state: assert property (@(posedge clk) disable iff (rst)
    (digit_count == '0) |-> (all_equal && sum1 == '0 && sum2 == '0))
    else $error("no digits seen but sums or flag disturbed");

endmodule

// ----- rtl/tic_check.sv -----
// Final check: mod-11 check digits, length and repetition tests, and the
// result register. Uses tic_pkg.
module tic_check import tic_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic fin_valid,
  input  fin_t fin,
  output logic out_valid,
  output logic is_valid
);

  logic ok;

  // verdict for one string
  always_comb begin
    ok = fin.len_ok && !fin.all_equal &&
         (fin.rx1 == expected_digit(fin.sum1)) &&
         (fin.rx2 == expected_digit(fin.sum2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin_valid) begin
      is_valid <= ok;
    end
  end

  a_bad_length: assert property (@(posedge clk) disable iff (rst)
    (adv && fin_valid && !fin.len_ok) |=> !is_valid)
    else $error("wrong-length string reported valid");

  a_repeated: assert property (@(posedge clk) disable iff (rst)
    (adv && fin_valid && fin.all_equal) |=> !is_valid)
    else $error("all-equal string reported valid");

endmodule

// ----- rtl/tax_id_check_digit_validator.sv -----
// Top level of the tax identifier check-digit validator: input register,
// mode register, flow control, output buffer. Uses tic_pkg, tic_accum, tic_check.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   input    | in_valid, in_ready, char_code, last_char | in
//   result   | out_valid, out_ready, is_valid       | out
//   config   | cfg_wr_en, cfg_wr_data (id_kind)     | in
//
// One character is taken every cycle while in_ready is high; the result of a
// string is formed through the input register, the accumulator and the checker,
// in that order, once its last character is accepted. Reset (rst, synchronous)
// clears the mode to the individual number and empties all stages. A result
// that is not taken moves to an output buffer; from the next cycle in_ready
// is low and the pipeline holds until that buffered result has been taken.
module tax_id_check_digit_validator import tic_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CharW-1:0] char_code,
  input  logic             last_char,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             is_valid,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data
);

  logic             adv;
  logic             id_kind;
  logic             s1_valid;
  logic [CharW-1:0] s1_char;
  logic             s1_last;
  logic             fin_valid;
  fin_t             fin;
  logic             res_valid;
  logic             res_bit;
  logic             buf_valid;
  logic             buf_bit;

  // pipeline moves whenever the output buffer is empty
  assign adv      = !buf_valid;
  assign in_ready = adv;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      id_kind <= KindIndividual;
    end else if (cfg_wr_en) begin
      id_kind <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1_char <= char_code;
      s1_last <= last_char;
    end
  end

  tic_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .en        (adv && s1_valid),
    .kind      (id_kind),
    .char_code (s1_char),
    .last_char (s1_last),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  tic_check u_check (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .fin_valid (fin_valid),
    .fin       (fin),
    .out_valid (res_valid),
    .is_valid  (res_bit)
  );

  // output buffer: catches a refused result so the checker can move on
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (buf_valid) begin
      if (out_ready) buf_valid <= 1'b0;
    end else if (res_valid && !out_ready) begin
      buf_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!buf_valid && res_valid && !out_ready) begin
      buf_bit <= res_bit;
    end
  end

  // buffered result goes first
  assign out_valid = buf_valid || res_valid;
  assign is_valid  = buf_valid ? buf_bit : res_bit;

  a_no_item_no_result: assert property (@(posedge clk) disable iff (rst)
    (adv && !fin_valid) |=> !res_valid)
    else $error("result raised without a finished string");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(is_valid)))
    else $error("waiting result dropped or changed");

endmodule
